// File: sv/pbrt_pkg.sv
package pbrt_pkg;

	// Width of the length counters (region, data and expected size).
	localparam int COUNT_BITS = 32;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT     = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EXPECTED_SIZE = 2'd2;

	// PackBits control codes.
	localparam logic [7:0] CODE_NOP    = 8'h80;
	localparam logic [8:0] RUN_OFFSET  = 9'd257;

	typedef enum logic [2:0] {
		PH_HI,
		PH_LO,
		PH_CTRL,
		PH_RUN,
		PH_LIT
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_FAIL = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       first_byte;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_value;
		logic [7:0] repeat_count;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [15:0]           row_count;
		logic [COUNT_BITS-1:0] region_length;
		logic [COUNT_BITS-1:0] expected_size;
	} cfg_t;

	// Results caused by one byte: a count of zero to two, in order.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} step_res_t;

endpackage

// File: sv/pbrt_core.sv
module pbrt_core import pbrt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  item_t     item,
	input  cfg_t      cfg,
	output step_res_t res
);

	localparam int CB = COUNT_BITS;
	localparam logic [CB+1:0] SAT_TOTAL = {2'b01, {CB{1'b0}}};

	phase_t        phase_q,    nx_phase;
	logic [15:0]   rows_q,     nx_rows;
	logic [7:0]    hold_q,     nx_hold;
	logic [CB:0]   total_q,    nx_total;
	logic [CB-1:0] region_q,   nx_region;
	logic [CB-1:0] data_q,     nx_data;
	logic [CB:0]   produced_q, nx_produced;
	logic [7:0]    pending_q,  nx_pending;
	logic          done_q,     nx_done;

	logic [CB:0]   need;
	logic [CB:0]   exp_w;
	logic [CB+1:0] sum;
	logic [CB:0]   sum_sat;
	logic [CB-1:0] dl;
	logic [CB:0]   room;
	logic [7:0]    rep;
	logic [15:0]   rows_dec;
	logic [7:0]    b;
	logic          fin, ok, bnd, emit;
	logic [CB-1:0] bnd_dl;
	logic [CB:0]   bnd_prod;
	result_t       data_res, stat_res;

	always_comb begin
		b        = item.byte_value;
		need     = (CB+1)'({cfg.row_count, 1'b0});
		exp_w    = {1'b0, cfg.expected_size};
		sum      = {1'b0, total_q} + (CB+2)'({hold_q, b});
		sum_sat  = (sum > SAT_TOTAL) ? SAT_TOTAL[CB:0] : sum[CB:0];
		dl       = data_q - CB'(1);
		room     = exp_w - produced_q;
		rep      = ((CB+1)'(pending_q) < room) ? pending_q : room[7:0];
		rows_dec = rows_q - 16'd1;

		nx_phase    = phase_q;
		nx_rows     = rows_q;
		nx_hold     = hold_q;
		nx_total    = total_q;
		nx_region   = region_q;
		nx_data     = data_q;
		nx_produced = produced_q;
		nx_pending  = pending_q;
		nx_done     = done_q;
		fin         = 1'b0;
		ok          = 1'b0;
		bnd         = 1'b0;
		bnd_dl      = data_q;
		bnd_prod    = produced_q;
		emit        = 1'b0;
		data_res    = '{kind: KIND_DATA, data_value: b, repeat_count: 8'd1, last: 1'b0};

		if (step) begin
			if (item.first_byte) begin
				nx_phase    = PH_HI;
				nx_rows     = cfg.row_count;
				nx_hold     = '0;
				nx_total    = '0;
				nx_data     = '0;
				nx_produced = '0;
				nx_pending  = '0;
				nx_done     = 1'b0;
				if (need > {1'b0, cfg.region_length}) begin
					fin = 1'b1;
				end else begin
					nx_region = cfg.region_length - need[CB-1:0];
					if (cfg.row_count == 16'd0) begin
						// No table: nothing to decode, done at once.
						fin = 1'b1;
						ok  = (cfg.expected_size == '0);
					end else begin
						nx_hold  = b;
						nx_phase = PH_LO;
					end
				end
			end else if (!done_q) begin
				case (phase_q)
					PH_HI: begin
						nx_hold  = b;
						nx_phase = PH_LO;
					end
					PH_LO: begin
						nx_total = sum_sat;
						nx_rows  = rows_dec;
						if (rows_dec == 16'd0) begin
							if (sum_sat > {1'b0, region_q}) begin
								fin = 1'b1;
							end else begin
								nx_data = sum_sat[CB-1:0];
								bnd     = 1'b1;
								bnd_dl  = sum_sat[CB-1:0];
							end
						end else begin
							nx_phase = PH_HI;
						end
					end
					PH_CTRL: begin
						nx_data = dl;
						if (b == CODE_NOP) begin
							bnd    = 1'b1;
							bnd_dl = dl;
						end else if (b > CODE_NOP) begin
							if (dl == '0) begin
								fin = 1'b1;
							end else begin
								nx_pending = 8'(RUN_OFFSET - {1'b0, b});
								nx_phase   = PH_RUN;
							end
						end else begin
							nx_pending = b + 8'd1;
							if (CB'({1'b0, b} + 9'd1) > dl) begin
								fin = 1'b1;
							end else begin
								nx_phase = PH_LIT;
							end
						end
					end
					PH_RUN: begin
						nx_data       = dl;
						emit          = 1'b1;
						data_res.repeat_count = rep;
						nx_produced   = produced_q + (CB+1)'(rep);
						nx_pending    = '0;
						bnd           = 1'b1;
						bnd_dl        = dl;
						bnd_prod      = produced_q + (CB+1)'(rep);
					end
					PH_LIT: begin
						nx_data     = dl;
						emit        = 1'b1;
						nx_produced = produced_q + (CB+1)'(1);
						nx_pending  = pending_q - 8'd1;
						if (pending_q == 8'd1) begin
							bnd      = 1'b1;
							bnd_dl   = dl;
							bnd_prod = produced_q + (CB+1)'(1);
						end
					end
					default: begin
						nx_phase = PH_HI;
					end
				endcase
			end

			// Packet boundary: end the job or fetch the next control byte.
			if (bnd) begin
				if (bnd_dl == '0 || bnd_prod >= exp_w) begin
					fin = 1'b1;
					ok  = (bnd_prod == exp_w);
				end else begin
					nx_phase = PH_CTRL;
				end
			end
			if (fin) begin
				nx_done = 1'b1;
			end
		end

		stat_res = '{kind: (ok ? KIND_OK : KIND_FAIL), data_value: 8'd0,
			repeat_count: 8'd0, last: 1'b1};

		res = '0;
		if (emit && fin) begin
			res.n  = 2'd2;
			res.r0 = data_res;
			res.r1 = stat_res;
		end else if (emit) begin
			res.n       = 2'd1;
			res.r0      = data_res;
			res.r0.last = 1'b1;
		end else if (fin) begin
			res.n  = 2'd1;
			res.r0 = stat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HI;
			rows_q     <= '0;
			hold_q     <= '0;
			total_q    <= '0;
			region_q   <= '0;
			data_q     <= '0;
			produced_q <= '0;
			pending_q  <= '0;
			done_q     <= 1'b1;
		end else begin
			phase_q    <= nx_phase;
			rows_q     <= nx_rows;
			hold_q     <= nx_hold;
			total_q    <= nx_total;
			region_q   <= nx_region;
			data_q     <= nx_data;
			produced_q <= nx_produced;
			pending_q  <= nx_pending;
			done_q     <= nx_done;
		end
	end

endmodule

// File: sv/pbrt_outq.sv
module pbrt_outq import pbrt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  step_res_t push,
	output logic      room,
	output logic      result_valid,
	input  logic      result_ready,
	output result_t   result
);

	// Three-entry shift queue; entry 0 is the beat on the port.
	result_t    q_q [3];
	result_t    nq  [3];
	logic [1:0] cnt_q;
	logic [1:0] base;
	logic       pop;

	assign pop          = result_valid && result_ready;
	assign result_valid = (cnt_q != 2'd0);
	assign result       = q_q[0];
	// At most one beat waiting leaves space for the two a byte can cause.
	assign room         = (cnt_q <= 2'd1);
	assign base         = cnt_q - {1'b0, pop};

	always_comb begin
		nq[0] = pop ? q_q[1] : q_q[0];
		nq[1] = pop ? q_q[2] : q_q[1];
		nq[2] = q_q[2];
		for (int i = 0; i < 3; i++) begin
			if (push.n != 2'd0 && base == 2'(i)) begin
				nq[i] = push.r0;
			end
			if (push.n == 2'd2 && base + 2'd1 == 2'(i)) begin
				nq[i] = push.r1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			q_q[i] <= nq[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + push.n;
		end
	end

endmodule

// File: sv/packbits_row_table_decoder.sv
// PackBits decoder for a region that opens with a table of big-endian 16-bit
// row lengths. Software writes row_count, region_length and expected_size on
// the cfg port while the block is idle, then streams the region one byte per
// beat on the item channel, with first_byte set on the beat that opens a job.
// Each byte causes zero, one or two beats on the result channel: decoded data
// (a run as one beat with a repeat count, literal bytes one beat each) and,
// at the end of every job, one status beat that reports success or failure.
// The last field marks the final beat caused by one input byte.
// A byte taken into the input register is decoded from it into the result
// queue, from which its first result beat is driven on the port.
// Throughput: one byte per cycle while the result queue has room. A byte that
// causes two beats (the last data of a job plus its status) pushes both at once.
// Decoding is a single pass from the input register into a three-entry result
// queue; the input side keeps taking bytes as long as at most one result beat
// is waiting, so a stalled receiver backs up at most three beats before
// item_ready drops.
// Reset clears the configuration registers to zero, empties the queue and
// leaves the decoder idle: bytes without first_byte are dropped until a job
// is opened. Bytes that arrive after a job has ended are dropped as well.
module packbits_row_table_decoder import pbrt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  item_t                     item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output result_t                   result
);

	cfg_t      cfg_q;
	logic      valid_s1;
	item_t     item_s1;
	logic      room;
	logic      step;
	step_res_t step_res;

	// Configuration registers; the user must write them only while no job is in flight, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT:     cfg_q.row_count     <= cfg_data[15:0];
				REG_REGION_LENGTH: cfg_q.region_length <= COUNT_BITS'(cfg_data);
				REG_EXPECTED_SIZE: cfg_q.expected_size <= COUNT_BITS'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Input register. The byte in it is decoded as soon as the result queue
	// has space for two beats; the register refills in that same cycle.
	assign step       = valid_s1 && room;
	assign item_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	pbrt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (step_res)
	);

	pbrt_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (step_res),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
